// ----- rtl/core/pop_pkg.sv -----
// Shared types, codes and constants of the Poisson change-point segmentation block.
package pop_pkg;

    // Default sizing of the block.
    localparam int MAX_POINTS_DEF     = 64;
    localparam int LOG_TABLE_BITS_DEF = 10;

    // Fixed field widths.
    localparam int PEN_W  = 40;
    localparam int END_W  = 6;
    localparam int MEAN_W = 32;
    localparam int COST_W = 64;

    // Penalty above 100000.0 in Q24.16 selects one segment for the whole sequence.
    localparam logic [PEN_W-1:0] HUGE_PENALTY = 40'd6553600000;

    // ln(2) in Q.32.
    localparam logic [31:0] LN2_Q32 = 32'd2977044472;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_ALL_ZERO = 2'd1,
        STATUS_OVERFLOW = 2'd2
    } status_t;

    typedef struct packed {
        logic [15:0] count;
        logic [15:0] weight;
        logic        last_point;
    } in_beat_t;

    typedef struct packed {
        logic [END_W-1:0]         segment_end;
        logic [MEAN_W-1:0]        segment_mean;
        logic signed [COST_W-1:0] segment_cost;
        status_t                  status;
        logic                     last_segment;
    } out_beat_t;

    // Datapath operations issued by the controller.
    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_RD,
        OP_SETUP,
        OP_DIV,
        OP_LN0,
        OP_LN1,
        OP_MUL,
        OP_COST,
        OP_TOT,
        OP_CMP,
        OP_STORE,
        OP_BT_INIT,
        OP_BT_RD,
        OP_BT_NEXT,
        OP_ERR,
        OP_EM_POP,
        OP_EM_RD,
        OP_EM_SETUP,
        OP_EM_OUT,
        OP_FIN
    } op_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_RD,
        ST_SETUP,
        ST_DIV,
        ST_LN0,
        ST_LN1,
        ST_MUL,
        ST_COST,
        ST_TOT,
        ST_CMP,
        ST_STORE,
        ST_LAST,
        ST_ERR,
        ST_BT_RD,
        ST_BT_NEXT,
        ST_EM_POP,
        ST_EM_RD,
        ST_EM_SETUP,
        ST_EM_DIV,
        ST_EM_LN0,
        ST_EM_OUT,
        ST_FIN
    } state_t;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic j_done;
        logic div_last;
        logic last_item;
        logic seq_err;
        logic bt_done;
        logic em_done;
        logic out_free;
    } dp_status_t;

endpackage

// ----- rtl/core/pop_ctrl.sv -----
// Controller state machine that sequences the candidate scan, backtrack and emission.
module pop_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  pop_pkg::dp_status_t status,
    output pop_pkg::cmd_t       cmd
);

    pop_pkg::state_t state_reg;
    pop_pkg::state_t state_next;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= pop_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            pop_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = status.full ? pop_pkg::ST_LAST : pop_pkg::ST_RD;
                end
            end
            pop_pkg::ST_RD:    state_next = pop_pkg::ST_SETUP;
            pop_pkg::ST_SETUP: state_next = pop_pkg::ST_DIV;
            pop_pkg::ST_DIV: begin
                if (status.div_last) begin
                    state_next = pop_pkg::ST_LN0;
                end
            end
            pop_pkg::ST_LN0:  state_next = pop_pkg::ST_LN1;
            pop_pkg::ST_LN1:  state_next = pop_pkg::ST_MUL;
            pop_pkg::ST_MUL:  state_next = pop_pkg::ST_COST;
            pop_pkg::ST_COST: state_next = pop_pkg::ST_TOT;
            pop_pkg::ST_TOT:  state_next = pop_pkg::ST_CMP;
            pop_pkg::ST_CMP: begin
                state_next = status.j_done ? pop_pkg::ST_STORE : pop_pkg::ST_RD;
            end
            pop_pkg::ST_STORE: state_next = pop_pkg::ST_LAST;
            pop_pkg::ST_LAST: begin
                if (!status.last_item) begin
                    state_next = pop_pkg::ST_IDLE;
                end else if (status.seq_err) begin
                    state_next = pop_pkg::ST_ERR;
                end else begin
                    state_next = pop_pkg::ST_BT_RD;
                end
            end
            pop_pkg::ST_ERR: begin
                if (status.out_free) begin
                    state_next = pop_pkg::ST_FIN;
                end
            end
            pop_pkg::ST_BT_RD: state_next = pop_pkg::ST_BT_NEXT;
            pop_pkg::ST_BT_NEXT: begin
                state_next = status.bt_done ? pop_pkg::ST_EM_POP : pop_pkg::ST_BT_RD;
            end
            pop_pkg::ST_EM_POP:   state_next = pop_pkg::ST_EM_RD;
            pop_pkg::ST_EM_RD:    state_next = pop_pkg::ST_EM_SETUP;
            pop_pkg::ST_EM_SETUP: state_next = pop_pkg::ST_EM_DIV;
            pop_pkg::ST_EM_DIV: begin
                if (status.div_last) begin
                    state_next = pop_pkg::ST_EM_LN0;
                end
            end
            pop_pkg::ST_EM_LN0: state_next = pop_pkg::ST_EM_OUT;
            pop_pkg::ST_EM_OUT: begin
                if (status.out_free) begin
                    state_next = status.em_done ? pop_pkg::ST_FIN : pop_pkg::ST_EM_POP;
                end
            end
            pop_pkg::ST_FIN: state_next = pop_pkg::ST_IDLE;
            default:         state_next = pop_pkg::ST_IDLE;
        endcase
    end

    // Outputs: input handshake and datapath operation.
    always_comb begin
        s_ready = 1'b0;
        cmd.op  = pop_pkg::OP_NONE;
        unique case (state_reg)
            pop_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.op = pop_pkg::OP_LOAD;
                end
            end
            pop_pkg::ST_RD:      cmd.op = pop_pkg::OP_RD;
            pop_pkg::ST_SETUP:   cmd.op = pop_pkg::OP_SETUP;
            pop_pkg::ST_DIV:     cmd.op = pop_pkg::OP_DIV;
            pop_pkg::ST_LN0:     cmd.op = pop_pkg::OP_LN0;
            pop_pkg::ST_LN1:     cmd.op = pop_pkg::OP_LN1;
            pop_pkg::ST_MUL:     cmd.op = pop_pkg::OP_MUL;
            pop_pkg::ST_COST:    cmd.op = pop_pkg::OP_COST;
            pop_pkg::ST_TOT:     cmd.op = pop_pkg::OP_TOT;
            pop_pkg::ST_CMP:     cmd.op = pop_pkg::OP_CMP;
            pop_pkg::ST_STORE:   cmd.op = pop_pkg::OP_STORE;
            pop_pkg::ST_LAST:    cmd.op = pop_pkg::OP_BT_INIT;
            pop_pkg::ST_ERR: begin
                if (status.out_free) begin
                    cmd.op = pop_pkg::OP_ERR;
                end
            end
            pop_pkg::ST_BT_RD:    cmd.op = pop_pkg::OP_BT_RD;
            pop_pkg::ST_BT_NEXT:  cmd.op = pop_pkg::OP_BT_NEXT;
            pop_pkg::ST_EM_POP:   cmd.op = pop_pkg::OP_EM_POP;
            pop_pkg::ST_EM_RD:    cmd.op = pop_pkg::OP_EM_RD;
            pop_pkg::ST_EM_SETUP: cmd.op = pop_pkg::OP_EM_SETUP;
            pop_pkg::ST_EM_DIV:   cmd.op = pop_pkg::OP_DIV;
            pop_pkg::ST_EM_LN0:   cmd.op = pop_pkg::OP_LN0;
            pop_pkg::ST_EM_OUT: begin
                if (status.out_free) begin
                    cmd.op = pop_pkg::OP_EM_OUT;
                end
            end
            pop_pkg::ST_FIN: cmd.op = pop_pkg::OP_FIN;
            default:         cmd.op = pop_pkg::OP_NONE;
        endcase
    end

    // An accepted beat always starts a scan or goes straight to the end-of-item check.
    a_load_next: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.op == pop_pkg::OP_LOAD |=>
            (state_reg == pop_pkg::ST_RD || state_reg == pop_pkg::ST_LAST))
        else $error("load not followed by scan or end check");

    // The divider is never left before its last step.
    a_div_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == pop_pkg::ST_DIV && !status.div_last) |=> state_reg == pop_pkg::ST_DIV)
        else $error("divider left early");

    // A beat is taken exactly when the controller issues a load.
    a_load_match: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) == (cmd.op == pop_pkg::OP_LOAD))
        else $error("load and input handshake disagree");

endmodule

// ----- rtl/core/pop_dp.sv -----
// Datapath: prefix memories, shared divider, log table, cost arithmetic and output register.
module pop_dp #(
    parameter int MAX_POINTS     = pop_pkg::MAX_POINTS_DEF,
    parameter int LOG_TABLE_BITS = pop_pkg::LOG_TABLE_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  pop_pkg::cmd_t                  cmd,
    output pop_pkg::dp_status_t            status,
    input  pop_pkg::in_beat_t              s_data,
    input  logic                           cfg_wr_en,
    input  logic [pop_pkg::PEN_W-1:0]      cfg_wr_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output pop_pkg::out_beat_t             m_data
);

    localparam int IW       = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW       = $clog2(MAX_POINTS + 1);
    localparam int WW       = 16 + IW;
    localparam int YW       = 32 + IW;
    localparam int TAB_SIZE = 1 << LOG_TABLE_BITS;
    localparam int LW       = 22;
    localparam int MW       = 21;

    typedef logic [31:0] ln_tab_t [TAB_SIZE];

    // ln(1 + k/2^L) in Q.32: log2 by repeated squaring in Q2.30, then scaled by ln 2.
    function automatic ln_tab_t build_ln_tab();
        ln_tab_t     t;
        logic [63:0] y;
        logic [63:0] l;
        for (int k = 0; k < TAB_SIZE; k++) begin
            y = (64'd1 << 30) + (64'(k) << (30 - LOG_TABLE_BITS));
            l = 64'd0;
            for (int b = 31; b >= 0; b--) begin
                y = (y * y) >> 30;
                if (y >= (64'd2 << 30)) begin
                    y    = y >> 1;
                    l[b] = 1'b1;
                end
            end
            t[k] = 32'((l * 64'(pop_pkg::LN2_Q32) + 64'h8000_0000) >> 32);
        end
        return t;
    endfunction

    localparam ln_tab_t LN_TAB = build_ln_tab();

    // Signed add that clamps at the 64-bit limits.
    function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [63:0] s;
        s = a + b;
        if (!a[63] && !b[63] && s[63]) begin
            return {1'b0, {63{1'b1}}};
        end else if (a[63] && b[63] && !s[63]) begin
            return {1'b1, {63{1'b0}}};
        end
        return s;
    endfunction

    // Configuration and sequence control state.
    logic [pop_pkg::PEN_W-1:0] pen_reg;
    logic [CW-1:0]             total_reg;
    logic                      any_nz_reg;
    logic                      ovf_reg;
    logic                      last_reg;
    logic                      first_reg;
    logic [IW-1:0]             j_reg;
    logic [IW-1:0]             jend_reg;
    logic [CW-1:0]             sp_reg;
    logic [IW-1:0]             bt_reg;

    // Prefix sums through the newest point.
    logic [WW-1:0] cur_w_reg;
    logic [YW-1:0] cur_y_reg;

    // Memories and their read registers.
    logic [WW-1:0]        rw_mem  [MAX_POINTS];
    logic [YW-1:0]        ry_mem  [MAX_POINTS];
    logic signed [63:0]   bc_mem  [MAX_POINTS];
    logic [IW-1:0]        bs_mem  [MAX_POINTS];
    logic [IW-1:0]        stk_mem [MAX_POINTS];
    logic [WW-1:0]        rw_rd_reg;
    logic [YW-1:0]        ry_rd_reg;
    logic signed [63:0]   bc_rd_reg;
    logic [IW-1:0]        bs_rd_reg;
    logic [IW-1:0]        stk_rd_reg;

    // Segment operands and divider.
    logic [WW-1:0]      w_reg;
    logic [YW-1:0]      y_reg;
    logic signed [63:0] base_reg;
    logic [WW:0]        rem_reg;
    logic [31:0]        num_reg;
    logic [31:0]        q_reg;
    logic [4:0]         p_reg;
    logic               found_reg;
    logic [4:0]         div_cnt_reg;
    logic               sat_reg;
    logic               wz_reg;

    // Log and cost pipeline.
    logic [31:0]               m_reg;
    logic [4:0]                pf_reg;
    logic [31:0]               tab_reg;
    logic signed [63:0]        t1_reg;
    logic signed [LW-1:0]      l_reg;
    logic signed [63:0]        t2_reg;
    logic signed [63:0]        cost_reg;
    logic signed [63:0]        tot_reg;
    logic signed [63:0]        best_reg;
    logic [IW-1:0]             bj_reg;

    // Emission.
    logic [IW-1:0]      e_reg;
    logic [WW-1:0]      prev_w_reg;
    logic [YW-1:0]      prev_y_reg;
    logic signed [63:0] segcost_reg;
    logic               m_valid_reg;
    pop_pkg::out_beat_t m_data_reg;

    // Combinational helpers.
    logic [IW-1:0]      i_idx;
    logic               full;
    logic               zero_mode;
    logic               huge_mode;
    logic [WW-1:0]      ld_w;
    logic [YW-1:0]      ld_y;
    logic [IW-1:0]      rd_addr;
    logic [WW-1:0]      seg_w;
    logic [YW-1:0]      seg_y;
    logic [WW:0]        rem2;
    logic               ge;
    logic [31:0]        m_fin;
    logic [4:0]         p_fin;
    logic [WW+31:0]     prod1;
    logic [31:0]        norm;
    logic signed [5:0]  pexp;
    logic signed [39:0] lsum;
    logic signed [39:0] lround;
    logic [MW-1:0]      lmag;
    logic [YW+MW-1:0]   prod2;
    logic [63:0]        t2mag;
    logic               out_free;

    assign i_idx     = total_reg[IW-1:0];
    assign full      = total_reg >= CW'(MAX_POINTS);
    assign zero_mode = pen_reg == '0;
    assign huge_mode = pen_reg > pop_pkg::HUGE_PENALTY;
    assign out_free  = !m_valid_reg || m_ready;

    // New prefix sums; a fresh sequence starts from zero.
    assign ld_w = (total_reg == '0 ? '0 : cur_w_reg) + WW'(s_data.weight);
    assign ld_y = (total_reg == '0 ? '0 : cur_y_reg)
                + YW'(s_data.count) * YW'(s_data.weight);

    assign rd_addr = (cmd.op == pop_pkg::OP_EM_RD) ? stk_rd_reg : j_reg - IW'(1);

    // Segment sums: from a candidate start to the newest point, or for an emitted segment.
    always_comb begin
        if (cmd.op == pop_pkg::OP_EM_SETUP) begin
            seg_w = rw_rd_reg - prev_w_reg;
            seg_y = ry_rd_reg - prev_y_reg;
        end else begin
            seg_w = cur_w_reg - (j_reg == '0 ? '0 : rw_rd_reg);
            seg_y = cur_y_reg - (j_reg == '0 ? '0 : ry_rd_reg);
        end
    end

    // One restoring division step.
    assign rem2 = {rem_reg[WW-1:0], num_reg[31]};
    assign ge   = rem2 >= {1'b0, w_reg};

    // Final mean with saturation and the zero-weight case; exponent of its top set bit.
    always_comb begin
        if (wz_reg) begin
            m_fin = '0;
            p_fin = '0;
        end else if (sat_reg) begin
            m_fin = '1;
            p_fin = 5'd31;
        end else begin
            m_fin = q_reg;
            p_fin = p_reg;
        end
        prod1 = (WW+32)'(w_reg) * (WW+32)'(m_fin);
        norm  = m_fin << (5'd31 - p_fin);
    end

    // Natural log in Q.16, rounded half up.
    always_comb begin
        pexp   = $signed({1'b0, pf_reg}) - 6'sd16;
        lsum   = 40'(pexp) * $signed(40'(pop_pkg::LN2_Q32))
               + $signed(40'(tab_reg));
        lround = (lsum + 40'sd32768) >>> 16;
        lmag   = l_reg[LW-1] ? MW'(-l_reg) : MW'(l_reg);
        prod2  = (YW+MW)'(y_reg) * (YW+MW)'(lmag);
        t2mag  = 64'(prod2 >> 8);
    end

    // Configuration and sequence control.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pen_reg    <= '0;
            total_reg  <= '0;
            any_nz_reg <= 1'b0;
            ovf_reg    <= 1'b0;
            last_reg   <= 1'b0;
            sp_reg     <= '0;
        end else begin
            if (cfg_wr_en) begin
                pen_reg <= cfg_wr_data;
            end
            if (cmd.op == pop_pkg::OP_LOAD) begin
                last_reg <= s_data.last_point;
                if (full) begin
                    ovf_reg <= 1'b1;
                end else if (s_data.count != '0) begin
                    any_nz_reg <= 1'b1;
                end
            end
            if (cmd.op == pop_pkg::OP_STORE) begin
                total_reg <= total_reg + CW'(1);
            end
            if (cmd.op == pop_pkg::OP_BT_INIT) begin
                sp_reg <= '0;
            end
            if (cmd.op == pop_pkg::OP_BT_RD) begin
                sp_reg <= sp_reg + CW'(1);
            end
            if (cmd.op == pop_pkg::OP_EM_POP) begin
                sp_reg <= sp_reg - CW'(1);
            end
            if (cmd.op == pop_pkg::OP_FIN) begin
                total_reg  <= '0;
                any_nz_reg <= 1'b0;
                ovf_reg    <= 1'b0;
            end
        end
    end

    // Memories with registered reads.
    always_ff @(posedge aclk) begin
        if (cmd.op == pop_pkg::OP_LOAD && !full) begin
            rw_mem[i_idx] <= ld_w;
            ry_mem[i_idx] <= ld_y;
        end
        if (cmd.op == pop_pkg::OP_STORE) begin
            bc_mem[i_idx] <= best_reg;
            bs_mem[i_idx] <= bj_reg;
        end
        if (cmd.op == pop_pkg::OP_BT_RD) begin
            stk_mem[sp_reg[IW-1:0]] <= bt_reg;
            bs_rd_reg               <= bs_mem[bt_reg];
        end
        if (cmd.op == pop_pkg::OP_RD || cmd.op == pop_pkg::OP_EM_RD) begin
            rw_rd_reg <= rw_mem[rd_addr];
            ry_rd_reg <= ry_mem[rd_addr];
            bc_rd_reg <= bc_mem[rd_addr];
        end
        if (cmd.op == pop_pkg::OP_EM_POP) begin
            stk_rd_reg <= stk_mem[sp_reg[IW-1:0] - IW'(1)];
        end
    end

    // Scan, divider, cost pipeline and backtrack registers.
    always_ff @(posedge aclk) begin
        if (cmd.op == pop_pkg::OP_LOAD && !full) begin
            cur_w_reg <= ld_w;
            cur_y_reg <= ld_y;
            j_reg     <= zero_mode ? i_idx : '0;
            jend_reg  <= huge_mode ? '0 : i_idx;
            first_reg <= 1'b1;
        end
        // Divider setup for a candidate or an emitted segment.
        if (cmd.op == pop_pkg::OP_SETUP || cmd.op == pop_pkg::OP_EM_SETUP) begin
            w_reg       <= seg_w;
            y_reg       <= seg_y;
            rem_reg     <= (WW+1)'(seg_y >> 16);
            num_reg     <= {seg_y[15:0], 16'd0};
            q_reg       <= '0;
            p_reg       <= '0;
            found_reg   <= 1'b0;
            div_cnt_reg <= 5'd31;
            sat_reg     <= seg_y >= {seg_w, 16'd0};
            wz_reg      <= seg_w == '0;
        end
        if (cmd.op == pop_pkg::OP_SETUP) begin
            base_reg <= (j_reg == '0) ? 64'sd0
                      : sat_add(bc_rd_reg, $signed(64'(pen_reg)));
        end
        if (cmd.op == pop_pkg::OP_EM_SETUP) begin
            prev_w_reg  <= rw_rd_reg;
            prev_y_reg  <= ry_rd_reg;
            segcost_reg <= bc_rd_reg;
        end
        if (cmd.op == pop_pkg::OP_DIV) begin
            rem_reg     <= ge ? rem2 - {1'b0, w_reg} : rem2;
            num_reg     <= num_reg << 1;
            q_reg       <= {q_reg[30:0], ge};
            div_cnt_reg <= div_cnt_reg - 5'd1;
            if (ge && !found_reg) begin
                p_reg     <= div_cnt_reg;
                found_reg <= 1'b1;
            end
        end
        // The log table is read here with a registered address-to-data path.
        if (cmd.op == pop_pkg::OP_LN0) begin
            m_reg   <= m_fin;
            pf_reg  <= p_fin;
            tab_reg <= LN_TAB[norm[30 -: LOG_TABLE_BITS]];
            t1_reg  <= $signed(64'(prod1 >> 8));
        end
        if (cmd.op == pop_pkg::OP_LN1) begin
            l_reg <= lround[LW-1:0];
        end
        if (cmd.op == pop_pkg::OP_MUL) begin
            t2_reg <= l_reg[LW-1] ? -$signed(t2mag) : $signed(t2mag);
        end
        if (cmd.op == pop_pkg::OP_COST) begin
            cost_reg <= t1_reg - t2_reg;
        end
        if (cmd.op == pop_pkg::OP_TOT) begin
            tot_reg <= sat_add(base_reg, cost_reg);
        end
        // Keep the earliest start among equal costs.
        if (cmd.op == pop_pkg::OP_CMP) begin
            first_reg <= 1'b0;
            if (first_reg || tot_reg < best_reg) begin
                best_reg <= tot_reg;
                bj_reg   <= j_reg;
            end
            if (j_reg != jend_reg) begin
                j_reg <= j_reg + IW'(1);
            end
        end
        if (cmd.op == pop_pkg::OP_BT_INIT) begin
            bt_reg     <= i_idx - IW'(1);
            prev_w_reg <= '0;
            prev_y_reg <= '0;
        end
        if (cmd.op == pop_pkg::OP_BT_NEXT) begin
            bt_reg <= bs_rd_reg - IW'(1);
        end
        if (cmd.op == pop_pkg::OP_EM_RD) begin
            e_reg <= stk_rd_reg;
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.op == pop_pkg::OP_EM_OUT || cmd.op == pop_pkg::OP_ERR) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.op == pop_pkg::OP_EM_OUT) begin
            m_data_reg.segment_end  <= pop_pkg::END_W'(e_reg);
            m_data_reg.segment_mean <= m_reg;
            m_data_reg.segment_cost <= segcost_reg;
            m_data_reg.status       <= pop_pkg::STATUS_OK;
            m_data_reg.last_segment <= sp_reg == '0;
        end else if (cmd.op == pop_pkg::OP_ERR) begin
            m_data_reg.segment_end  <= '0;
            m_data_reg.segment_mean <= '0;
            m_data_reg.segment_cost <= '0;
            m_data_reg.status       <= ovf_reg ? pop_pkg::STATUS_OVERFLOW
                                               : pop_pkg::STATUS_ALL_ZERO;
            m_data_reg.last_segment <= 1'b1;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Status to the controller.
    assign status.full      = full;
    assign status.j_done    = j_reg == jend_reg;
    assign status.div_last  = div_cnt_reg == '0;
    assign status.last_item = last_reg;
    assign status.seq_err   = ovf_reg || !any_nz_reg || total_reg == '0;
    assign status.bt_done   = bs_rd_reg == '0;
    assign status.em_done   = sp_reg == '0;
    assign status.out_free  = out_free;

    // The segment stack never holds more entries than points.
    a_sp_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        sp_reg <= CW'(MAX_POINTS))
        else $error("segment stack overrun");

    // The point count never passes capacity.
    a_total_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        total_reg <= CW'(MAX_POINTS))
        else $error("point count past capacity");

    // A result is only loaded when the output register is free.
    a_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == pop_pkg::OP_EM_OUT || cmd.op == pop_pkg::OP_ERR) |->
            (!m_valid_reg || m_ready))
        else $error("output register overwritten");

endmodule

// ----- rtl/core/poisson_optimal_partitioning.sv -----
// Each point is scanned over its candidate start points, one start at a time.
// Normal mode scans i + 1 start points; a penalty of zero or above 1e5 scans one.
// The 32-step shared divider serves each start; the last point adds a backtrack over the
// segments and the emission of one beat per segment, which the receiver can stall.
// One point is in work at a time. Reset (aresetn low, synchronous) clears the penalty,
// the point count and the flags; the memories need no clearing.
module poisson_optimal_partitioning #(
    parameter int MAX_POINTS     = pop_pkg::MAX_POINTS_DEF,
    parameter int LOG_TABLE_BITS = pop_pkg::LOG_TABLE_BITS_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  pop_pkg::in_beat_t         s_data,
    output logic                      m_valid,
    input  logic                      m_ready,
    output pop_pkg::out_beat_t        m_data,
    input  logic                      cfg_wr_en,
    input  logic [pop_pkg::PEN_W-1:0] cfg_wr_data
);

    pop_pkg::cmd_t       cmd;
    pop_pkg::dp_status_t status;

    // Sequencer.
    pop_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // Arithmetic and storage.
    pop_dp #(
        .MAX_POINTS     (MAX_POINTS),
        .LOG_TABLE_BITS (LOG_TABLE_BITS)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .status      (status),
        .s_data      (s_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

endmodule
